// ----- design/kpls_pkg.sv -----
// ----------------------------------------------------------------------------
// kpls_pkg
// Shared types and constants for the keyframe position sampler: field widths,
// request codes, the key memory word and the controller/datapath interface.
// ----------------------------------------------------------------------------
package kpls_pkg;

  // fixed field widths
  localparam int STAMP_W = 32;
  localparam int COORD_W = 32;
  localparam int SLOT_W  = 6;
  localparam int SEG_W   = 6;
  localparam int COUNT_W = 7;

  // request codes
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // axis selector for the shared multiplier
  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } kpls_axis_t;

  // one key as stored in memory
  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } kpls_key_t;

  // controller to datapath commands
  typedef struct packed {
    logic       wr_key;       // store the incoming key
    logic       load_sample;  // latch sample time and key count, rewind index
    logic       advance;      // move scan one key forward
    logic       pick_cur;     // result is the key under the index
    logic       pick_prev;    // result is the key before the index
    logic       div_start;    // load divider operands
    logic       div_step;     // one quotient bit
    logic       mul;          // multiply one axis delta by the factor
    logic       add;          // add scaled delta to the start value
    kpls_axis_t axis;
    logic       emit;         // move held result into the output register
  } kpls_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic single;        // only one key in use
    logic before_first;  // sample time below key 0
    logic hit;           // sample time below the key under the index
    logic degenerate;    // zero-length or backward segment, or sample time below its start
    logic at_last;       // index is on the last key in use
    logic out_free;      // output register can take a result
  } kpls_status_t;

endpackage

// ----- design/kpls_ctrl.sv -----
// ----------------------------------------------------------------------------
// kpls_ctrl
// Sequencer for the sampler: request intake, key scan, divide steps and the
// per-axis multiply/add, then hand-off to the output register.
// ----------------------------------------------------------------------------
module kpls_ctrl import kpls_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         in_cmd,
  output logic         in_ready,
  input  kpls_status_t sts,
  output kpls_cmd_t    cmd
);

  localparam int DCW = $clog2(FRAC_BITS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_SCAN,
    ST_DIV,
    ST_MUL,
    ST_ADD,
    ST_EMIT
  } state_t;

  state_t           state_r, state_nxt;
  logic [DCW-1:0]   div_cnt_r, div_cnt_nxt;
  kpls_axis_t       axis_r, axis_nxt;

  assign in_ready = (state_r == ST_IDLE);

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    div_cnt_nxt = div_cnt_r;
    axis_nxt    = axis_r;
    cmd         = '0;
    cmd.axis    = axis_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_cmd == CMD_WRITE) begin
            cmd.wr_key = 1'b1;
          end else begin
            cmd.load_sample = 1'b1;
            state_nxt       = ST_FIRST;
          end
        end
      end
      ST_FIRST: begin
        if (sts.single || sts.before_first) begin
          cmd.pick_cur = 1'b1;
          state_nxt    = ST_EMIT;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.hit) begin
          if (sts.degenerate) begin
            cmd.pick_prev = 1'b1;
            state_nxt     = ST_EMIT;
          end else begin
            cmd.div_start = 1'b1;
            div_cnt_nxt   = '0;
            state_nxt     = ST_DIV;
          end
        end else if (sts.at_last) begin
          cmd.pick_cur = 1'b1;
          state_nxt    = ST_EMIT;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_nxt  = div_cnt_r + 1'b1;
        if (div_cnt_r == DCW'(FRAC_BITS - 1)) begin
          axis_nxt  = AXIS_X;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        cmd.add = 1'b1;
        case (axis_r)
          AXIS_X:  begin axis_nxt = AXIS_Y; state_nxt = ST_MUL; end
          AXIS_Y:  begin axis_nxt = AXIS_Z; state_nxt = ST_MUL; end
          default: state_nxt = ST_EMIT;
        endcase
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      div_cnt_r <= '0;
      axis_r    <= AXIS_X;
    end else begin
      state_r   <= state_nxt;
      div_cnt_r <= div_cnt_nxt;
      axis_r    <= axis_nxt;
    end
  end

endmodule

// ----- design/kpls_dp.sv -----
// ----------------------------------------------------------------------------
// kpls_dp
// Datapath for the sampler: key memory, scan registers, restoring divider,
// shared axis multiplier, result hold and output register, key count register.
// ----------------------------------------------------------------------------
module kpls_dp import kpls_pkg::*; #(
  parameter int MAX_KEYS  = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  kpls_cmd_t                 cmd,
  output kpls_status_t              sts,
  input  logic [SLOT_W-1:0]         in_key_slot,
  input  logic [STAMP_W-1:0]        in_key_time,
  input  logic signed [COORD_W-1:0] in_key_x,
  input  logic signed [COORD_W-1:0] in_key_y,
  input  logic signed [COORD_W-1:0] in_key_z,
  input  logic [STAMP_W-1:0]        in_sample_time,
  input  logic                      cfg_wr_en,
  input  logic [COUNT_W-1:0]        cfg_wr_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [COORD_W-1:0] out_x,
  output logic signed [COORD_W-1:0] out_y,
  output logic signed [COORD_W-1:0] out_z,
  output logic [SEG_W-1:0]          out_segment
);

  localparam int AW  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CW  = ($clog2(MAX_KEYS + 1) > COUNT_W) ? $clog2(MAX_KEYS + 1) : COUNT_W;
  localparam int DW  = COORD_W + 1;
  localparam int PW  = DW + FRAC_BITS + 1;

  // key memory and scan state
  kpls_key_t           mem [MAX_KEYS];
  kpls_key_t           rdata_r, prev_r, end_r;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [CW-1:0]       n_r, n_nxt;
  logic [CW-1:0]       kc_ext;
  logic [STAMP_W-1:0]  t_r;
  logic [COUNT_W-1:0]  key_count_r;
  logic                slot_ok;

  // divider
  logic [STAMP_W-1:0]  rem_r, den_r;
  logic [STAMP_W:0]    rem2;
  logic                ge;
  logic [FRAC_BITS-1:0] quot_r;

  // multiplier and adder
  logic [COORD_W-1:0]     a_sel, b_sel;
  logic signed [DW-1:0]   delta;
  logic signed [PW-1:0]   delta_ext, fac_ext, prod_r, shifted;
  logic [COORD_W+1:0]     sum;

  // result hold and output register
  logic [COORD_W-1:0] res_x_r, res_y_r, res_z_r;
  logic [SEG_W-1:0]   res_seg_r;
  logic               out_valid_r;
  logic [COORD_W-1:0] out_x_r, out_y_r, out_z_r;
  logic [SEG_W-1:0]   out_seg_r;

  // key count register, clamped into 1..MAX_KEYS when a sample starts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r <= COUNT_W'(1);
    end else if (cfg_wr_en) begin
      key_count_r <= cfg_wr_data;
    end
  end

  assign kc_ext = CW'(key_count_r);

  always_comb begin
    if (kc_ext == '0) begin
      n_nxt = CW'(1);
    end else if (kc_ext > CW'(MAX_KEYS)) begin
      n_nxt = CW'(MAX_KEYS);
    end else begin
      n_nxt = kc_ext;
    end
  end

  // scan index
  always_comb begin
    if (cmd.load_sample) begin
      idx_nxt = '0;
    end else if (cmd.advance) begin
      idx_nxt = idx_r + 1'b1;
    end else begin
      idx_nxt = idx_r;
    end
  end

  assign slot_ok = (CW'(in_key_slot) < CW'(MAX_KEYS));

  // memory: one write, one registered read that follows the scan index
  always_ff @(posedge clk) begin
    if (cmd.wr_key && slot_ok) begin
      mem[AW'(in_key_slot)] <= '{stamp: in_key_time, x: in_key_x, y: in_key_y, z: in_key_z};
    end
    rdata_r <= mem[idx_nxt[AW-1:0]];
  end

  // scan registers
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.load_sample) begin
      t_r <= in_sample_time;
      n_r <= n_nxt;
    end
    if (cmd.advance) begin
      prev_r <= rdata_r;
    end
    if (cmd.div_start) begin
      end_r <= rdata_r;
    end
  end

  // status
  always_comb begin
    sts.single       = (n_r == CW'(1));
    sts.before_first = (t_r < rdata_r.stamp);
    sts.hit          = (t_r < rdata_r.stamp);
    sts.degenerate   = (rdata_r.stamp <= prev_r.stamp) || (t_r < prev_r.stamp);
    sts.at_last      = (idx_r == n_r - 1'b1);
    sts.out_free     = !out_valid_r || out_ready;
  end

  // restoring divider, one quotient bit per step
  assign rem2 = {rem_r, 1'b0};
  assign ge   = (rem2 >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r  <= t_r - prev_r.stamp;
      den_r  <= rdata_r.stamp - prev_r.stamp;
      quot_r <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= ge ? STAMP_W'(rem2 - {1'b0, den_r}) : rem2[STAMP_W-1:0];
      quot_r <= {quot_r[FRAC_BITS-2:0], ge};
    end
  end

  // axis operand select
  always_comb begin
    case (cmd.axis)
      AXIS_X:  begin a_sel = prev_r.x; b_sel = end_r.x; end
      AXIS_Y:  begin a_sel = prev_r.y; b_sel = end_r.y; end
      AXIS_Z:  begin a_sel = prev_r.z; b_sel = end_r.z; end
      default: begin a_sel = prev_r.x; b_sel = end_r.x; end
    endcase
  end

  // delta times factor, then floor shift and add to start
  assign delta     = $signed({b_sel[COORD_W-1], b_sel}) - $signed({a_sel[COORD_W-1], a_sel});
  assign delta_ext = PW'(delta);
  assign fac_ext   = $signed(PW'({1'b0, quot_r}));
  assign shifted   = prod_r >>> FRAC_BITS;
  assign sum       = {{2{a_sel[COORD_W-1]}}, a_sel} + shifted[COORD_W+1:0];

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= delta_ext * fac_ext;
    end
  end

  // result hold
  always_ff @(posedge clk) begin
    if (cmd.pick_cur) begin
      res_x_r   <= rdata_r.x;
      res_y_r   <= rdata_r.y;
      res_z_r   <= rdata_r.z;
      res_seg_r <= idx_r[SEG_W-1:0];
    end else if (cmd.pick_prev) begin
      res_x_r   <= prev_r.x;
      res_y_r   <= prev_r.y;
      res_z_r   <= prev_r.z;
      res_seg_r <= SEG_W'(idx_r - 1'b1);
    end else if (cmd.div_start) begin
      res_seg_r <= SEG_W'(idx_r - 1'b1);
    end else if (cmd.add) begin
      case (cmd.axis)
        AXIS_X:  res_x_r <= sum[COORD_W-1:0];
        AXIS_Y:  res_y_r <= sum[COORD_W-1:0];
        default: res_z_r <= sum[COORD_W-1:0];
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_x_r   <= res_x_r;
      out_y_r   <= res_y_r;
      out_z_r   <= res_z_r;
      out_seg_r <= res_seg_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_x       = out_x_r;
  assign out_y       = out_y_r;
  assign out_z       = out_z_r;
  assign out_segment = out_seg_r;

endmodule

// ----- design/keyframe_position_lerp_sampler.sv -----
// ----------------------------------------------------------------------------
// keyframe_position_lerp_sampler
// Keyframe table with linear interpolation of an xyz position at a sample time.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   cmd, key slot/time/xyz, sample time
//   out_     output     out_valid / out_ready x, y, z, segment
//   cfg_     input      cfg_wr_en             key count
//
// A key write request returns nothing.
// A sample request, for n keys in use, takes one memory read per key during the
// scan, one divider step per factor bit, then a multiply and an add per axis
// on the shared multiplier.
// A finished result sits in the output register while the next request is
// taken; a result waiting behind a stalled output holds the block.
// Reset sets the key count to one; key memory is undefined until written.
// ----------------------------------------------------------------------------
module keyframe_position_lerp_sampler import kpls_pkg::*; #(
  parameter int MAX_KEYS  = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_cmd,
  input  logic [SLOT_W-1:0]         in_key_slot,
  input  logic [STAMP_W-1:0]        in_key_time,
  input  logic signed [COORD_W-1:0] in_key_x,
  input  logic signed [COORD_W-1:0] in_key_y,
  input  logic signed [COORD_W-1:0] in_key_z,
  input  logic [STAMP_W-1:0]        in_sample_time,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [COORD_W-1:0] out_x,
  output logic signed [COORD_W-1:0] out_y,
  output logic signed [COORD_W-1:0] out_z,
  output logic [SEG_W-1:0]          out_segment,
  input  logic                      cfg_wr_en,
  input  logic [COUNT_W-1:0]        cfg_wr_data
);

  kpls_cmd_t    cmd;
  kpls_status_t sts;

  // sequencer
  kpls_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // memory and arithmetic
  kpls_dp #(
    .MAX_KEYS  (MAX_KEYS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_key_slot    (in_key_slot),
    .in_key_time    (in_key_time),
    .in_key_x       (in_key_x),
    .in_key_y       (in_key_y),
    .in_key_z       (in_key_z),
    .in_sample_time (in_sample_time),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_z          (out_z),
    .out_segment    (out_segment)
  );

endmodule

// ----- dv/keyframe_position_lerp_sampler_checker.sv -----
// ----------------------------------------------------------------------------
// keyframe_position_lerp_sampler_checker
// Watches the request, result and key-count ports of the sampler, keeps its
// own key table and key count, predicts each sample result and compares it
// field by field with what the block returns, in order.
// ----------------------------------------------------------------------------
module keyframe_position_lerp_sampler_checker import kpls_pkg::*; #(
  parameter int MAX_KEYS  = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic                      in_cmd,
  input  logic [SLOT_W-1:0]         in_key_slot,
  input  logic [STAMP_W-1:0]        in_key_time,
  input  logic signed [COORD_W-1:0] in_key_x,
  input  logic signed [COORD_W-1:0] in_key_y,
  input  logic signed [COORD_W-1:0] in_key_z,
  input  logic [STAMP_W-1:0]        in_sample_time,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic signed [COORD_W-1:0] out_x,
  input  logic signed [COORD_W-1:0] out_y,
  input  logic signed [COORD_W-1:0] out_z,
  input  logic [SEG_W-1:0]          out_segment,
  input  logic                      cfg_wr_en,
  input  logic [COUNT_W-1:0]        cfg_wr_data,
  output int                        mismatches,
  output int                        pending,
  output int                        samples_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [SEG_W-1:0]   segment;
  } pos_sample_t;

  logic [STAMP_W-1:0] stamp_mem [MAX_KEYS];
  logic [COORD_W-1:0] x_mem     [MAX_KEYS];
  logic [COORD_W-1:0] y_mem     [MAX_KEYS];
  logic [COORD_W-1:0] z_mem     [MAX_KEYS];
  logic [COUNT_W-1:0] key_count_q;
  pos_sample_t        pos_due_q [$];

  // key count as the block uses it: zero acts as one, large values clamp
  function automatic int active_keys();
    if (key_count_q == 0) return 1;
    if (key_count_q > MAX_KEYS) return MAX_KEYS;
    return int'(key_count_q);
  endfunction

  function automatic pos_sample_t key_result(input int k, input int seg);
    pos_sample_t r;
    r.x       = x_mem[k];
    r.y       = y_mem[k];
    r.z       = z_mem[k];
    r.segment = SEG_W'(seg);
    return r;
  endfunction

  // start + (end - start) * fac, product floored back to Q16.16
  function automatic logic [COORD_W-1:0] lerp_axis(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b,
                                                   input logic [63:0] fac);
    longint s, d, p;
    s = longint'($signed(a));
    d = longint'($signed(b)) - s;
    p = d * longint'(fac);
    return COORD_W'(s + (p >>> FRAC_BITS));
  endfunction

  // segment search, clamping and blend for one sample time
  function automatic pos_sample_t sample_track(input logic [STAMP_W-1:0] t);
    int n, seg, i;
    logic [STAMP_W-1:0] t1, t2;
    logic [63:0] fac;
    pos_sample_t r;
    n = active_keys();
    if (n == 1 || t < stamp_mem[0]) return key_result(0, 0);
    seg = n;
    for (i = 0; i + 1 < n; i++) begin
      if (seg == n && t < stamp_mem[i+1]) seg = i;
    end
    if (seg == n) return key_result(n - 1, n - 1);
    t1 = stamp_mem[seg];
    t2 = stamp_mem[seg+1];
    if (t2 <= t1 || t < t1) return key_result(seg, seg);
    fac = ({32'd0, t - t1} << FRAC_BITS) / {32'd0, t2 - t1};
    r.x       = lerp_axis(x_mem[seg], x_mem[seg+1], fac);
    r.y       = lerp_axis(y_mem[seg], y_mem[seg+1], fac);
    r.z       = lerp_axis(z_mem[seg], z_mem[seg+1], fac);
    r.segment = SEG_W'(seg);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
    end
  endtask

  // track config writes, requests and results at each rising edge
  always @(posedge clk) begin
    pos_sample_t due;
    if (!rst_n) begin
      key_count_q = COUNT_W'(1);
      pos_due_q.delete();
    end else begin
      if (cfg_wr_en) key_count_q = cfg_wr_data;
      if (in_valid && in_ready) begin
        if (in_cmd == CMD_WRITE) begin
          stamp_mem[in_key_slot] = in_key_time;
          x_mem[in_key_slot]     = in_key_x;
          y_mem[in_key_slot]     = in_key_y;
          z_mem[in_key_slot]     = in_key_z;
        end else begin
          pos_due_q.push_back(sample_track(in_sample_time));
        end
      end
      if (out_valid && out_ready) begin
        if (pos_due_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual x=%h y=%h z=%h seg=%0d",
                   $time, out_x, out_y, out_z, out_segment);
        end else begin
          due = pos_due_q.pop_front();
          check_field("x", due.x, out_x);
          check_field("y", due.y, out_y);
          check_field("z", due.z, out_z);
          check_field("segment", 32'(due.segment), 32'(out_segment));
          samples_checked++;
        end
      end
    end
    pending = pos_due_q.size();
  end

endmodule

// ----- dv/tb_keyframe_position_lerp_sampler.sv -----
// ----------------------------------------------------------------------------
// tb_keyframe_position_lerp_sampler
// Drives key writes and sample requests into the sampler under several key
// counts and stall mixes; a checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module tb_keyframe_position_lerp_sampler;
  timeunit 1ns;
  timeprecision 1ps;
  import kpls_pkg::*;

  localparam int MAX_KEYS      = 64;
  localparam int FRAC_BITS     = 16;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 128;
  localparam int NUM_PHASES    = 9;
  localparam int PHASE_ITEMS   = 155;

  logic                      clk            = 1'b0;
  logic                      rst_n          = 1'b0;
  logic                      in_valid       = 1'b0;
  logic                      in_ready;
  logic                      in_cmd         = CMD_WRITE;
  logic [SLOT_W-1:0]         in_key_slot    = '0;
  logic [STAMP_W-1:0]        in_key_time    = '0;
  logic signed [COORD_W-1:0] in_key_x       = '0;
  logic signed [COORD_W-1:0] in_key_y       = '0;
  logic signed [COORD_W-1:0] in_key_z       = '0;
  logic [STAMP_W-1:0]        in_sample_time = '0;
  logic                      out_valid;
  logic                      out_ready      = 1'b0;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic signed [COORD_W-1:0] out_z;
  logic [SEG_W-1:0]          out_segment;
  logic                      cfg_wr_en      = 1'b0;
  logic [COUNT_W-1:0]        cfg_wr_data    = '0;

  int mismatches, pending, samples_checked;
  int idle_pct  = 0;
  int stall_pct = 0;
  int sent_cnt  = 0;
  int write_cnt = 0;
  int sample_cnt = 0;
  int live_keys = 1;
  int cycle_cnt = 0;
  logic [STAMP_W-1:0] track_stamp [MAX_KEYS];

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  keyframe_position_lerp_sampler #(
    .MAX_KEYS  (MAX_KEYS),
    .FRAC_BITS (FRAC_BITS)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_key_slot    (in_key_slot),
    .in_key_time    (in_key_time),
    .in_key_x       (in_key_x),
    .in_key_y       (in_key_y),
    .in_key_z       (in_key_z),
    .in_sample_time (in_sample_time),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_z          (out_z),
    .out_segment    (out_segment),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  keyframe_position_lerp_sampler_checker #(
    .MAX_KEYS  (MAX_KEYS),
    .FRAC_BITS (FRAC_BITS)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_key_slot     (in_key_slot),
    .in_key_time     (in_key_time),
    .in_key_x        (in_key_x),
    .in_key_y        (in_key_y),
    .in_key_z        (in_key_z),
    .in_sample_time  (in_sample_time),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_x           (out_x),
    .out_y           (out_y),
    .out_z           (out_z),
    .out_segment     (out_segment),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .mismatches      (mismatches),
    .pending         (pending),
    .samples_checked (samples_checked)
  );

  // result side back-pressure
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= stall_pct);
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_cnt, pending);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // present one request at a falling edge and hold it until accepted
  task automatic push_request(input logic cmd, input logic [SLOT_W-1:0] slot,
                              input logic [STAMP_W-1:0] stamp,
                              input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input logic [COORD_W-1:0] z,
                              input logic [STAMP_W-1:0] t);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    in_cmd         = cmd;
    in_key_slot    = slot;
    in_key_time    = stamp;
    in_key_x       = x;
    in_key_y       = y;
    in_key_z       = z;
    in_sample_time = t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    sent_cnt++;
  endtask

  task automatic write_key(input logic [SLOT_W-1:0] slot, input logic [STAMP_W-1:0] stamp,
                           input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                           input logic [COORD_W-1:0] z);
    track_stamp[slot] = stamp;
    write_cnt++;
    push_request(CMD_WRITE, slot, stamp, x, y, z, $urandom());
  endtask

  task automatic sample_at(input logic [STAMP_W-1:0] t);
    sample_cnt++;
    push_request(CMD_SAMPLE, SLOT_W'($urandom()), $urandom(), $urandom(), $urandom(),
                 $urandom(), t);
  endtask

  // let every result drain and the block go quiet
  task automatic settle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_key_count(input logic [COUNT_W-1:0] cnt);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = cnt;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    live_keys   = (cnt == 0) ? 1 : (cnt > MAX_KEYS) ? MAX_KEYS : int'(cnt);
  endtask

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom_range(32'h8_0000) - 32'h4_0000;
      default: return $urandom();
    endcase
  endfunction

  // sample times around keys, at the ends and inside the track
  function automatic logic [STAMP_W-1:0] pick_time(input int n);
    logic [STAMP_W-1:0] lo, hi, key;
    lo  = track_stamp[0];
    hi  = track_stamp[n-1];
    key = track_stamp[$urandom_range(n - 1)];
    case ($urandom_range(7))
      0:       return $urandom();
      1:       return key;
      2:       return key + 1;
      3:       return key - 1;
      4:       return '0;
      5:       return '1;
      default: return (hi > lo) ? lo + $urandom_range(hi - lo) : $urandom();
    endcase
  endfunction

  // fill slots 0..n-1 with non-decreasing times, some times repeated
  task automatic load_track(input int n);
    logic [63:0] acc, span;
    int i;
    case ($urandom_range(3))
      0:       span = 64'd16;
      1:       span = 64'h1_0000;
      2:       span = 64'h100_0000;
      default: span = 64'hffff_ffff / n;
    endcase
    acc = ($urandom_range(3) == 0) ? 64'd0 : 64'($urandom_range(32'(span)));
    for (i = 0; i < n; i++) begin
      write_key(SLOT_W'(i), (acc > 64'hffff_ffff) ? 32'hffff_ffff : acc[31:0],
                rand_coord(), rand_coord(), rand_coord());
      if ($urandom_range(9) != 0) acc += 64'($urandom_range(1, 32'(span)));
    end
  endtask

  function automatic logic [COUNT_W-1:0] phase_key_count(input int ph);
    case (ph)
      0:       return 7'd0;
      1:       return 7'd5;
      2:       return 7'd127;
      3:       return 7'd2;
      4:       return 7'd64;
      5:       return 7'd1;
      6:       return 7'd12;
      7:       return 7'd33;
      default: return COUNT_W'($urandom_range(1, MAX_KEYS));
    endcase
  endfunction

  initial begin : stimulus
    int ph, n, roll, budget;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // single key: before it, past it, and the top slot out of use
    set_key_count(7'd1);
    write_key(6'd0, 32'h0001_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000);
    sample_at(32'h0000_0000);
    sample_at(32'hffff_ffff);
    write_key(6'd63, 32'hffff_ffff, rand_coord(), rand_coord(), rand_coord());

    // four keys with a zero-length segment and full-scale deltas
    settle();
    set_key_count(7'd4);
    write_key(6'd1, 32'h0002_0000, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
    write_key(6'd2, 32'h0002_0000, 32'h0000_0000, 32'h1234_5678, 32'h0000_0001);
    write_key(6'd3, 32'hffff_ffff, 32'h7fff_ffff, 32'hedcb_a988, 32'h8000_0000);
    sample_at(32'h0000_ffff);
    sample_at(32'h0001_0000);
    sample_at(32'h0001_8000);
    sample_at(32'h0001_ffff);
    sample_at(32'h0002_0000);
    sample_at(32'h8000_0000);
    sample_at(32'hffff_fffe);
    sample_at(32'hffff_ffff);

    // random phases: sorted tracks, sample bursts, stray key writes
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      idle_pct  = (ph < 3) ? 6 : (ph < 6) ? 86 : 0;
      stall_pct = (ph < 3) ? 86 : (ph < 6) ? 6 : 0;
      set_key_count(phase_key_count(ph));
      n = live_keys;
      budget = sent_cnt + PHASE_ITEMS;
      load_track(n);
      repeat (4) sample_at(pick_time(n));
      while (sent_cnt < budget) begin
        roll = $urandom_range(99);
        if (roll < 15) begin
          load_track(n);
        end else if (roll < 90) begin
          repeat ($urandom_range(2, 10)) sample_at(pick_time(n));
        end else begin
          write_key(SLOT_W'($urandom_range(MAX_KEYS - 1)), $urandom(),
                    rand_coord(), rand_coord(), rand_coord());
        end
      end
    end

    settle();
    $display("covered %0d requests: %0d key writes, %0d samples, %0d results checked",
             sent_cnt, write_cnt, sample_cnt, samples_checked);
    $display("key counts 0, 1, 2, 5, 12, 33, 64, 127 and one random, under three stall mixes");
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
